// ===== src/assert_macros.svh =====
// assertion helpers for the rtl, used by cbas_datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication with the consequent checked in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cbas_pkg.sv =====
`timescale 1ns / 1ps
package cbas_pkg;

  localparam int unsigned T_W       = 17;
  localparam int unsigned C_W       = 32;
  localparam int unsigned CFG_N     = 8;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [T_W-1:0] T_ONE      = 17'd65536;
  localparam logic [T_W-1:0] STEP_FLOOR = 17'd131;
  localparam logic [T_W-1:0] STEP_CEIL  = 17'd6554;
  localparam logic [34:0]    SIGMA      = 35'd6554;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL1_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL1_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL2_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL2_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_END_X   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_END_Y   = 3'd7;

  typedef struct packed {
    logic restart;
    logic set_first;
    logic set_half;
    logic set_dbl;
    logic run;
    logic take;
    logic test_sum;
    logic test_abs;
    logic mode_dbl;
    logic commit;
    logic none;
  } cmd_t;

  typedef struct packed {
    logic done_cond;
    logic small_step;
    logic big_step;
    logic dbl_over;
    logic straight;
    logic eval_done;
    logic out_free;
  } sts_t;

endpackage

// ===== src/cbas_datapath.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cbas_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cbas_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cbas_pkg::C_W-1:0]         cfg_wdata_i,
  input  cbas_pkg::cmd_t                   cmd_i,
  output cbas_pkg::sts_t                   sts_o,
  input  logic                             out_stall_i,
  output logic                             out_valid_o,
  output logic signed [cbas_pkg::C_W-1:0]  point_x_o,
  output logic signed [cbas_pkg::C_W-1:0]  point_y_o,
  output logic [cbas_pkg::T_W-1:0]         t_reached_o,
  output logic                             last_o,
  output logic                             no_segment_o
);
  import cbas_pkg::*;

  logic signed [C_W-1:0] cfg_q [CFG_N];
  logic [T_W-1:0] t_now_q, step_q, nt_q, ct_q;
  logic signed [C_W-1:0] prev_x_q, prev_y_q, nx_q, ny_q, cx_q, cy_q;
  logic fin_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CFG_N; i++) cfg_q[i] <= '0;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // step arithmetic
  logic [T_W-1:0] span, first_nt, step_eff;
  logic [T_W:0]   first_sum, half_sum, dbl_sum;
  assign span      = nt_q - t_now_q;
  assign step_eff  = (step_q == '0) ? T_W'(1) : step_q;
  assign first_sum = {1'b0, t_now_q} + {1'b0, step_eff};
  assign first_nt  = (first_sum > {1'b0, T_ONE}) ? T_ONE : first_sum[T_W-1:0];
  assign half_sum  = {1'b0, t_now_q} + {1'b0, nt_q};
  assign dbl_sum   = {1'b0, t_now_q} + {span, 1'b0};

  // shared blend unit: one multiply then one round and add per blend
  logic       ax_q, ph_q, done_q;
  logic [2:0] k_q;
  logic signed [C_W-1:0] v_q [5];
  logic signed [C_W-1:0] base_q, op_a, op_b, p0, p1, p2, p3, blend_res;
  logic signed [C_W:0]   diff;
  logic signed [50:0]    prod_q, rnd_sum;
  logic                  ev_last;

  assign p0 = ax_q ? cfg_q[REG_START_Y] : cfg_q[REG_START_X];
  assign p1 = ax_q ? cfg_q[REG_CTRL1_Y] : cfg_q[REG_CTRL1_X];
  assign p2 = ax_q ? cfg_q[REG_CTRL2_Y] : cfg_q[REG_CTRL2_X];
  assign p3 = ax_q ? cfg_q[REG_END_Y]   : cfg_q[REG_END_X];

  always_comb begin
    case (k_q)
      3'd0:    begin op_a = p0;     op_b = p1;     end
      3'd1:    begin op_a = p1;     op_b = p2;     end
      3'd2:    begin op_a = p2;     op_b = p3;     end
      3'd3:    begin op_a = v_q[0]; op_b = v_q[1]; end
      3'd4:    begin op_a = v_q[1]; op_b = v_q[2]; end
      default: begin op_a = v_q[3]; op_b = v_q[4]; end
    endcase
  end

  assign diff      = {op_b[C_W-1], op_b} - {op_a[C_W-1], op_a};
  assign rnd_sum   = prod_q + 51'sd32768;
  assign blend_res = base_q + rnd_sum[47:16];
  assign ev_last   = ax_q && (k_q == 3'd5) && ph_q;

  // blend sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q <= 1'b0; ph_q <= 1'b0; k_q <= '0; done_q <= 1'b0;
    end else if (!cmd_i.run) begin
      ax_q <= 1'b0; ph_q <= 1'b0; k_q <= '0; done_q <= 1'b0;
    end else begin
      done_q <= ev_last;
      ph_q   <= ~ph_q;
      if (ph_q) begin
        if (k_q == 3'd5) begin
          k_q  <= '0;
          ax_q <= ~ax_q;
        end else begin
          k_q <= k_q + 3'd1;
        end
      end
    end
  end

  // blend operands and results
  always_ff @(posedge clk_i) begin
    if (cmd_i.run && !ph_q) begin
      prod_q <= 51'(diff * $signed({1'b0, ct_q}));
      base_q <= op_a;
    end
    if (cmd_i.run && ph_q) begin
      if (k_q != 3'd5) v_q[k_q] <= blend_res;
      else if (ax_q) cy_q <= blend_res;
      else cx_q <= blend_res;
    end
  end

  // flatness test: a registered sum, then a registered absolute deviation
  logic signed [C_W-1:0] mx, my, qx, qy;
  logic signed [C_W:0]   sx_q, sy_q;
  logic signed [C_W+1:0] dx, dy;
  logic [C_W+1:0]        absx_q, absy_q;
  assign mx = cmd_i.mode_dbl ? nx_q : cx_q;
  assign my = cmd_i.mode_dbl ? ny_q : cy_q;
  assign qx = cmd_i.mode_dbl ? cx_q : nx_q;
  assign qy = cmd_i.mode_dbl ? cy_q : ny_q;
  assign dx = {{2{mx[C_W-1]}}, mx} - {{2{sx_q[C_W]}}, sx_q[C_W:1]};
  assign dy = {{2{my[C_W-1]}}, my} - {{2{sy_q[C_W]}}, sy_q[C_W:1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.test_sum) begin
      sx_q <= {prev_x_q[C_W-1], prev_x_q} + {qx[C_W-1], qx};
      sy_q <= {prev_y_q[C_W-1], prev_y_q} + {qy[C_W-1], qy};
    end
    if (cmd_i.test_abs) begin
      absx_q <= dx[C_W+1] ? (C_W+2)'(0) - dx : dx;
      absy_q <= dy[C_W+1] ? (C_W+2)'(0) - dy : dy;
    end
  end

  // segment state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_now_q  <= '0;
      step_q   <= STEP_CEIL;
      prev_x_q <= '0;
      prev_y_q <= '0;
      fin_q    <= 1'b1;
    end else if (cmd_i.restart) begin
      t_now_q  <= '0;
      step_q   <= STEP_CEIL;
      prev_x_q <= cfg_q[REG_START_X];
      prev_y_q <= cfg_q[REG_START_Y];
      fin_q    <= 1'b0;
    end else if (cmd_i.commit) begin
      t_now_q  <= nt_q;
      step_q   <= span;
      prev_x_q <= nx_q;
      prev_y_q <= ny_q;
      fin_q    <= (nt_q >= T_ONE);
    end else if (cmd_i.none) begin
      fin_q    <= 1'b1;
    end
  end

  // trial point
  always_ff @(posedge clk_i) begin
    if (cmd_i.set_first) begin
      nt_q <= first_nt;
      ct_q <= first_nt;
    end else if (cmd_i.set_half) begin
      ct_q <= half_sum[T_W:1];
    end else if (cmd_i.set_dbl) begin
      ct_q <= dbl_sum[T_W-1:0];
    end
    if (cmd_i.take) begin
      nt_q <= ct_q;
      nx_q <= cx_q;
      ny_q <= cy_q;
    end
  end

  // output register
  logic out_valid_q, ld_out;
  assign ld_out = cmd_i.commit || cmd_i.none;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (ld_out) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      point_x_o    <= nx_q;
      point_y_o    <= ny_q;
      t_reached_o  <= nt_q;
      last_o       <= (nt_q >= T_ONE);
      no_segment_o <= 1'b0;
    end else if (cmd_i.none) begin
      point_x_o    <= cfg_q[REG_END_X];
      point_y_o    <= cfg_q[REG_END_Y];
      t_reached_o  <= T_ONE;
      last_o       <= 1'b0;
      no_segment_o <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  // status
  assign sts_o.done_cond  = fin_q || (t_now_q >= T_ONE);
  assign sts_o.small_step = span < STEP_FLOOR;
  assign sts_o.big_step   = span > STEP_CEIL;
  assign sts_o.dbl_over   = dbl_sum >= {1'b0, T_ONE};
  assign sts_o.straight   = ({1'b0, absx_q} + {1'b0, absy_q}) <= SIGMA;
  assign sts_o.eval_done  = done_q;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  `ASSERT_CLK(a_no_overwrite, !(ld_out && out_valid_q && out_stall_i), "result overwritten")
  `ASSERT_NEXT(a_t_bound, cmd_i.commit, t_now_q <= T_ONE, "t beyond one")
  `ASSERT_CLK(a_done_run, !done_q || cmd_i.run, "eval done without run")

endmodule

// ===== src/cbas_ctrl.sv =====
`timescale 1ns / 1ps
module cbas_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           restart_i,
  output logic           in_stall_o,
  input  cbas_pkg::sts_t sts_i,
  output cbas_pkg::cmd_t cmd_o
);
  import cbas_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_CHECK  = 16'h0002,
    S_EVN    = 16'h0004,
    S_HTEST  = 16'h0008,
    S_EVH    = 16'h0010,
    S_HSUM   = 16'h0020,
    S_HABS   = 16'h0040,
    S_HDEC   = 16'h0080,
    S_DTEST  = 16'h0100,
    S_EVD    = 16'h0200,
    S_DSUM   = 16'h0400,
    S_DABS   = 16'h0800,
    S_DDEC   = 16'h1000,
    S_COMMIT = 16'h2000,
    S_NONE   = 16'h4000,
    S_SPARE  = 16'h8000
  } state_e;

  state_e state_q, state_d;
  logic   reduced_q, reduced_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    reduced_d = reduced_q;
    cmd_o     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.restart = restart_i;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        reduced_d = 1'b0;
        if (sts_i.done_cond) begin
          state_d = S_NONE;
        end else begin
          cmd_o.set_first = 1'b1;
          state_d = S_EVN;
        end
      end
      S_EVN: begin
        cmd_o.run = 1'b1;
        if (sts_i.eval_done) begin
          cmd_o.take = 1'b1;
          state_d = S_HTEST;
        end
      end
      // halving trials
      S_HTEST: begin
        if (sts_i.small_step) begin
          state_d = reduced_q ? S_COMMIT : S_DTEST;
        end else begin
          cmd_o.set_half = 1'b1;
          state_d = S_EVH;
        end
      end
      S_EVH: begin
        cmd_o.run = 1'b1;
        if (sts_i.eval_done) state_d = S_HSUM;
      end
      S_HSUM: begin
        cmd_o.test_sum = 1'b1;
        state_d = S_HABS;
      end
      S_HABS: begin
        cmd_o.test_abs = 1'b1;
        state_d = S_HDEC;
      end
      S_HDEC: begin
        if (sts_i.straight) begin
          state_d = reduced_q ? S_COMMIT : S_DTEST;
        end else begin
          cmd_o.take = 1'b1;
          reduced_d  = 1'b1;
          state_d    = S_HTEST;
        end
      end
      // doubling trials
      S_DTEST: begin
        if (sts_i.big_step || sts_i.dbl_over) begin
          state_d = S_COMMIT;
        end else begin
          cmd_o.set_dbl = 1'b1;
          state_d = S_EVD;
        end
      end
      S_EVD: begin
        cmd_o.run = 1'b1;
        if (sts_i.eval_done) state_d = S_DSUM;
      end
      S_DSUM: begin
        cmd_o.mode_dbl = 1'b1;
        cmd_o.test_sum = 1'b1;
        state_d = S_DABS;
      end
      S_DABS: begin
        cmd_o.mode_dbl = 1'b1;
        cmd_o.test_abs = 1'b1;
        state_d = S_DDEC;
      end
      S_DDEC: begin
        if (sts_i.straight) begin
          cmd_o.take = 1'b1;
          state_d = S_DTEST;
        end else begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_NONE: begin
        if (sts_i.out_free) begin
          cmd_o.none = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      reduced_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      reduced_q <= reduced_d;
    end
  end

endmodule

// ===== src/cubic_bezier_adaptive_segmenter.sv =====
`timescale 1ns / 1ps
// Cubic Bezier flattener: each input beat asks for the next segment end point.
// Input channel: in_valid_i / in_stall_o with restart_i; restart 1 starts the
// curve at t zero from the configured start point.
// Output channel: out_valid_o / out_stall_i with point, t_reached, last and
// no_segment; one result beat per input beat, in order.
// Config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (start, ctrl1,
// ctrl2, end, x then y); the user must write them only while the block is idle,
// which the block itself does not enforce.
// A finished curve goes from the check state to the load; a segment evaluates
// the first curve point, then each halving or doubling trial a point and its
// tests, then the load; the shared 33x18 multiplier does a point's 12 blends.
// One item is in work at a time; in_stall_o is high until its result has
// been loaded into the output register.
// When the receiver stalls, the result holds in the output register and the
// block still takes the next item, waiting only before loading its result.
// Reset: config registers, t and position zero, no curve active (a request without
// restart returns no_segment), step back to its maximum, output empty.
module cubic_bezier_adaptive_segmenter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cbas_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cbas_pkg::C_W-1:0]         cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             restart_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [cbas_pkg::C_W-1:0]  point_x_o,
  output logic signed [cbas_pkg::C_W-1:0]  point_y_o,
  output logic [cbas_pkg::T_W-1:0]         t_reached_o,
  output logic                             last_o,
  output logic                             no_segment_o
);
  import cbas_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cbas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .restart_i  (restart_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cbas_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o),
    .t_reached_o  (t_reached_o),
    .last_o       (last_o),
    .no_segment_o (no_segment_o)
  );

endmodule
